@@ rtl/core/slp_pkg.sv @@
package slp_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 32;
  localparam int NRM_W  = 16;
  localparam int PEN_W  = 32;
  localparam int FI_W   = 4;

  localparam int A_W    = 2 * POS_W + 2 * NRM_W;
  localparam int B_W    = 2 * POS_W;
  localparam int OPD_W  = POS_W + 1;
  localparam int PRD_W  = OPD_W + NRM_W;
  localparam int SUM_W  = PRD_W + 1;
  localparam int FRAC_SH = 14;
  localparam int SH_W   = SUM_W - FRAC_SH;

  localparam logic [OP_W-1:0] OP_FACE = 2'd0;
  localparam logic [OP_W-1:0] OP_VERT = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic issue;
    logic is_dist;
    logic first;
    logic load_res;
    logic empty;
  } slp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } slp_sts_t;

endpackage

@@ rtl/core/slp_req_if.sv @@
interface slp_req_if import slp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [NRM_W-1:0] norm_x;
  logic signed [NRM_W-1:0] norm_y;

  modport source (output valid, opcode, pos_x, pos_y, norm_x, norm_y, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, norm_x, norm_y, output ready);
endinterface

@@ rtl/core/slp_res_if.sv @@
interface slp_res_if import slp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PEN_W-1:0] penetration;
  logic [FI_W-1:0]         face_index;
  logic                    valid_res;

  modport source (output valid, penetration, face_index, valid_res, input ready);
  modport sink (input valid, penetration, face_index, valid_res, output ready);
endinterface

@@ rtl/core/slp_ram.sv @@
module slp_ram #(
  parameter int W = 64,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/slp_dp.sv @@
module slp_dp import slp_pkg::*; #(
  parameter int MAX_A_FACES    = 16,
  parameter int MAX_B_VERTICES = 16,
  localparam int AW = $clog2(MAX_A_FACES),
  localparam int BW = $clog2(MAX_B_VERTICES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  slp_cmd_t                cmd,
  input  logic [AW-1:0]           a_idx,
  input  logic [BW-1:0]           b_idx,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [NRM_W-1:0] norm_x,
  input  logic signed [NRM_W-1:0] norm_y,
  output slp_sts_t                sts,
  output logic signed [PEN_W-1:0] penetration,
  output logic [FI_W-1:0]         face_index,
  output logic                    valid_res
);

  localparam int FW = (AW > FI_W) ? AW : FI_W;

  logic [A_W-1:0] a_rd;
  logic [B_W-1:0] b_rd;
  logic [BW-1:0]  b_raddr;

  logic          s1_v, s2_v, s3_v;
  logic          s1_dist, s2_dist, s3_dist;
  logic          s1_first, s2_first, s3_first;
  logic [AW-1:0] s1_i, s2_i, s3_i;
  logic [BW-1:0] s1_j, s2_j, s3_j;

  logic signed [POS_W-1:0] bx, by, ax, ay;
  logic signed [NRM_W-1:0] fnx, fny;
  logic signed [OPD_W-1:0] opx_c, opy_c;
  logic signed [OPD_W-1:0] s2_opx, s2_opy;
  logic signed [NRM_W-1:0] s2_nx, s2_ny;
  logic signed [PRD_W-1:0] s3_px, s3_py;
  logic signed [SUM_W-1:0] sum;

  logic signed [SUM_W-1:0] best_q;
  logic [BW-1:0]           best_s;
  logic signed [SUM_W-1:0] best_d;
  logic [AW-1:0]           best_i;

  logic signed [SH_W-1:0]  shd;
  logic [SH_W-PEN_W:0]     top_bits;
  logic                    ovf;
  logic [PEN_W-1:0]        sat;
  logic [FW-1:0]           fi_ext;

  assign b_raddr = cmd.is_dist ? best_s : b_idx;

  slp_ram #(.W(A_W), .D(MAX_A_FACES)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (a_idx),
    .wdata ({pos_x, pos_y, norm_x, norm_y}),
    .raddr (a_idx),
    .rdata (a_rd)
  );

  slp_ram #(.W(B_W), .D(MAX_B_VERTICES)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (b_idx),
    .wdata ({pos_x, pos_y}),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  assign bx  = $signed(b_rd[B_W-1:POS_W]);
  assign by  = $signed(b_rd[POS_W-1:0]);
  assign ax  = $signed(a_rd[A_W-1:A_W-POS_W]);
  assign ay  = $signed(a_rd[A_W-POS_W-1:2*NRM_W]);
  assign fnx = $signed(a_rd[2*NRM_W-1:NRM_W]);
  assign fny = $signed(a_rd[NRM_W-1:0]);

  always_comb begin
    if (s1_dist) begin
      opx_c = OPD_W'(bx) - OPD_W'(ax);
      opy_c = OPD_W'(by) - OPD_W'(ay);
    end else begin
      opx_c = OPD_W'(bx);
      opy_c = OPD_W'(by);
    end
  end

  assign sum = SUM_W'(s3_px) + SUM_W'(s3_py);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_dist  <= cmd.is_dist;
    s1_first <= cmd.first;
    s1_i     <= a_idx;
    s1_j     <= b_idx;

    s2_dist  <= s1_dist;
    s2_first <= s1_first;
    s2_i     <= s1_i;
    s2_j     <= s1_j;
    s2_opx   <= opx_c;
    s2_opy   <= opy_c;
    s2_nx    <= fnx;
    s2_ny    <= fny;

    s3_dist  <= s2_dist;
    s3_first <= s2_first;
    s3_i     <= s2_i;
    s3_j     <= s2_j;
    s3_px    <= PRD_W'(s2_opx * s2_nx);
    s3_py    <= PRD_W'(s2_opy * s2_ny);
  end

  always_ff @(posedge clk) begin
    if (s3_v && !s3_dist && (s3_first || sum < best_q)) begin
      best_q <= sum;
      best_s <= s3_j;
    end
    if (s3_v && s3_dist && (s3_first || sum > best_d)) begin
      best_d <= sum;
      best_i <= s3_i;
    end
  end

  assign sts.pipe_busy = s1_v | s2_v | s3_v;

  assign shd      = SH_W'(best_d >>> FRAC_SH);
  assign top_bits = shd[SH_W-1:PEN_W-1];
  assign ovf      = !((&top_bits) || !(|top_bits));
  assign sat      = ovf ? (shd[SH_W-1] ? {1'b1, {(PEN_W-1){1'b0}}} : {1'b0, {(PEN_W-1){1'b1}}})
                        : shd[PEN_W-1:0];
  assign fi_ext   = FW'(best_i);

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      if (cmd.empty) begin
        penetration <= '0;
        face_index  <= '0;
        valid_res   <= 1'b0;
      end else begin
        penetration <= $signed(sat);
        face_index  <= fi_ext[FI_W-1:0];
        valid_res   <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/slp_ctrl.sv @@
module slp_ctrl import slp_pkg::*; #(
  parameter int MAX_A_FACES    = 16,
  parameter int MAX_B_VERTICES = 16,
  localparam int AW  = $clog2(MAX_A_FACES),
  localparam int BW  = $clog2(MAX_B_VERTICES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [OP_W-1:0] req_opcode,
  output logic            req_ready,
  output logic            res_valid,
  input  logic            res_ready,
  output slp_cmd_t        cmd,
  input  slp_sts_t        sts,
  output logic [AW-1:0]   a_idx,
  output logic [BW-1:0]   b_idx
);

  localparam int ACW = $clog2(MAX_A_FACES + 1);
  localparam int BCW = $clog2(MAX_B_VERTICES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]     state, state_next;
  logic [ACW-1:0] a_count, a_count_next;
  logic [BCW-1:0] b_count, b_count_next;
  logic [AW-1:0]  i_cnt, i_cnt_next;
  logic [BW-1:0]  j_cnt, j_cnt_next;
  logic           res_full, res_full_next;
  logic           empty;
  logic           a_last, b_last;

  assign empty  = (a_count == '0) || (b_count == '0);
  assign a_last = (ACW'(i_cnt) + ACW'(1)) == a_count;
  assign b_last = (BCW'(j_cnt) + BCW'(1)) == b_count;

  assign req_ready = (state == ST_IDLE);
  assign res_valid = res_full;
  assign a_idx     = (state == ST_IDLE) ? a_count[AW-1:0] : i_cnt;
  assign b_idx     = (state == ST_IDLE) ? b_count[BW-1:0] : j_cnt;

  always_comb begin
    state_next    = state;
    a_count_next  = a_count;
    b_count_next  = b_count;
    i_cnt_next    = i_cnt;
    j_cnt_next    = j_cnt;
    res_full_next = res_full & ~res_ready;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req_opcode)
            OP_FACE: begin
              if (a_count < ACW'(MAX_A_FACES)) begin
                cmd.wr_a     = 1'b1;
                a_count_next = a_count + ACW'(1);
              end
            end
            OP_VERT: begin
              if (b_count < BCW'(MAX_B_VERTICES)) begin
                cmd.wr_b     = 1'b1;
                b_count_next = b_count + BCW'(1);
              end
            end
            OP_EVAL: begin
              i_cnt_next = '0;
              j_cnt_next = '0;
              state_next = empty ? ST_DONE : ST_SCAN;
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        cmd.first = (j_cnt == '0);
        if (b_last) begin
          state_next = ST_WAIT;
        end else begin
          j_cnt_next = j_cnt + BW'(1);
        end
      end
      ST_WAIT: begin
        if (!sts.pipe_busy) begin
          cmd.issue   = 1'b1;
          cmd.is_dist = 1'b1;
          cmd.first   = (i_cnt == '0);
          if (a_last) begin
            state_next = ST_DRAIN;
          end else begin
            i_cnt_next = i_cnt + AW'(1);
            j_cnt_next = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          cmd.load_res  = 1'b1;
          cmd.empty     = empty;
          a_count_next  = '0;
          b_count_next  = '0;
          res_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      a_count  <= '0;
      b_count  <= '0;
      i_cnt    <= '0;
      j_cnt    <= '0;
      res_full <= 1'b0;
    end else begin
      state    <= state_next;
      a_count  <= a_count_next;
      b_count  <= b_count_next;
      i_cnt    <= i_cnt_next;
      j_cnt    <= j_cnt_next;
      res_full <= res_full_next;
    end
  end

  a_eval_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && req_valid && req_opcode == OP_EVAL && !empty) |=> state == ST_SCAN)
    else $error("evaluate with loaded polygons did not start scan");

  a_dist_after_drain: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.is_dist) |-> !sts.pipe_busy)
    else $error("distance issued before support search retired");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res |-> !res_full)
    else $error("result loaded over a pending result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (a_count <= ACW'(MAX_A_FACES)) && (b_count <= BCW'(MAX_B_VERTICES)))
    else $error("load count beyond store depth");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !res_full) |=> (state == ST_IDLE && res_full && a_count == '0))
    else $error("finish did not post result and clear counts");

endmodule

@@ rtl/core/sat_least_penetration_axis.sv @@
// Load requests (append face of A, append vertex of B, no-op): one per cycle while the block is idle.
// Evaluate: the single B vertex memory read port walks every (face, vertex) pair and, after
//   each face's vertices, rereads that face's support; the result then goes to the result register.
// A new request is taken while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) clears both load counts, the controller and the
//   result valid (res.valid); vertex and normal memories and the valid_res flag are not cleared.
module sat_least_penetration_axis import slp_pkg::*; #(
  parameter int MAX_A_FACES    = 16,
  parameter int MAX_B_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  slp_req_if.sink     req,
  slp_res_if.source   res
);

  localparam int AW = $clog2(MAX_A_FACES);
  localparam int BW = $clog2(MAX_B_VERTICES);

  slp_cmd_t      cmd;
  slp_sts_t      sts;
  logic [AW-1:0] a_idx;
  logic [BW-1:0] b_idx;

  slp_ctrl #(
    .MAX_A_FACES    (MAX_A_FACES),
    .MAX_B_VERTICES (MAX_B_VERTICES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .cmd        (cmd),
    .sts        (sts),
    .a_idx      (a_idx),
    .b_idx      (b_idx)
  );

  slp_dp #(
    .MAX_A_FACES    (MAX_A_FACES),
    .MAX_B_VERTICES (MAX_B_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .a_idx       (a_idx),
    .b_idx       (b_idx),
    .pos_x       (req.pos_x),
    .pos_y       (req.pos_y),
    .norm_x      (req.norm_x),
    .norm_y      (req.norm_y),
    .sts         (sts),
    .penetration (res.penetration),
    .face_index  (res.face_index),
    .valid_res   (res.valid_res)
  );

endmodule
